// ----- sv/stepper_halfstep_ramp_driver_assert.svh -----
// assertion macros for the stepper half-step ramp driver
// no dependencies; included by the top level
`ifndef STEPPER_HALFSTEP_RAMP_DRIVER_ASSERT_SVH
`define STEPPER_HALFSTEP_RAMP_DRIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SRD_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SRD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srd_pkg.sv -----
// types and constants for the stepper half-step ramp driver
// no dependencies
package srd_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_OPEN  = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_REV_TARGET   = 3'd0;
    localparam logic [2:0] REG_STEPS_PER_REV = 3'd1;
    localparam logic [2:0] REG_PERIOD_START = 3'd2;
    localparam logic [2:0] REG_PERIOD_END   = 3'd3;
    localparam logic [2:0] REG_PERIOD_ACCEL = 3'd4;

    localparam logic [15:0] RST_REV_TARGET    = 16'd0;
    localparam logic [15:0] RST_STEPS_PER_REV = 16'd400;
    localparam logic [23:0] RST_PERIOD_START  = 24'd2000;
    localparam logic [23:0] RST_PERIOD_END    = 24'd500;
    localparam logic [23:0] RST_PERIOD_ACCEL  = 24'd10;

    localparam logic [3:0] HALF_PATTERN_INIT = 4'b0001;
    localparam logic [3:0] FULL_PATTERN_INIT = 4'b0011;

    typedef struct packed {
        logic [15:0] revolutions_target;
        logic [15:0] steps_per_revolution;
        logic [23:0] period_start;
        logic [23:0] period_end;
        logic [23:0] period_accel;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  coil_drive;
        logic        is_running;
        logic        sensor_power;
        logic [23:0] step_period;
    } res_t;

    function automatic logic [3:0] rotate_pattern(input logic [3:0] p, input logic closing);
        logic [3:0] r;
        if (closing)
        begin
            r = {p[2:0], p[3]};
        end
        else
        begin
            r = {p[0], p[3:1]};
        end
        return r;
    endfunction

endpackage

// ----- sv/stepper_halfstep_ramp_driver.sv -----
// top level of the stepper half-step ramp driver: input stage, core, result stage
// depends on srd_pkg, srd_cfg, srd_core and stepper_halfstep_ramp_driver_assert.svh
//
// usage:
//   command transactions (tick, close, open, stop plus both limit levels) enter on
//   in_valid/in_ready; each gives exactly one result transaction on out_valid/out_ready
//   carrying coil_drive, is_running, sensor_power and step_period
//   out_valid rises when the result register loads: an accepted transaction sits in the
//   input register, then one pass through the core next-state logic loads the result
//   register; throughput is one transaction per cycle while the receiver takes every result;
//   the core state registers update in the same cycle the result register loads, so a
//   following command sees them at once
//   when the receiver stalls, the result register holds, the input register still
//   takes one more transaction, and in_ready drops only when both are full
//   reset clears both stages and the motor state (idle, coils off, sensors off)
//   and loads the configuration registers with their defaults
//   configuration is written through the apb-style port with pready tied high,
//   register i at byte address 4*i; writes are meant for idle periods only
module stepper_halfstep_ramp_driver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srd_pkg::ADDR_W-1:0] paddr,
    input  logic [srd_pkg::DATA_W-1:0] pwdata,
    output logic [srd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic                       closed_switch,
    input  logic                       open_switch,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3:0]                 coil_drive,
    output logic                       is_running,
    output logic                       sensor_power,
    output logic [23:0]                step_period
);
    import srd_pkg::*;

`include "stepper_halfstep_ramp_driver_assert.svh"

    cfg_t       cfg;
    res_t       res;
    logic       in_vld_reg;
    logic [1:0] cmd_reg;
    logic       closed_reg;
    logic       open_reg;
    logic       out_vld_reg;
    res_t       out_reg;
    logic       advance;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    srd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .cmd       (cmd_t'(cmd_reg)),
        .closed_sw (closed_reg),
        .open_sw   (open_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg    <= command;
            closed_reg <= closed_switch;
            open_reg   <= open_switch;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign coil_drive   = out_reg.coil_drive;
    assign is_running   = out_reg.is_running;
    assign sensor_power = out_reg.sensor_power;
    assign step_period  = out_reg.step_period;

    `SRD_ASSERT_SAME(a_idle_coils_off, clk, rst_n, out_vld_reg && !out_reg.is_running, out_reg.coil_drive == 4'd0, "coils driven while stopped")
    `SRD_ASSERT_SAME(a_coil_pattern, clk, rst_n, out_vld_reg, $countones(out_reg.coil_drive) <= 2, "more than two coils driven")
    `SRD_ASSERT_SAME(a_run_sensors, clk, rst_n, out_vld_reg && out_reg.is_running, out_reg.sensor_power, "running with sensors off")
    `SRD_ASSERT_NEXT(a_input_held, clk, rst_n, in_vld_reg && !advance, in_vld_reg, "stalled input stage lost its transaction")

endmodule

// ----- sv/srd_cfg.sv -----
// configuration register bank with apb-style write and read access
// depends on srd_pkg
module srd_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srd_pkg::ADDR_W-1:0] paddr,
    input  logic [srd_pkg::DATA_W-1:0] pwdata,
    output logic [srd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output srd_pkg::cfg_t              cfg
);
    import srd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.revolutions_target   <= RST_REV_TARGET;
            cfg_reg.steps_per_revolution <= RST_STEPS_PER_REV;
            cfg_reg.period_start         <= RST_PERIOD_START;
            cfg_reg.period_end           <= RST_PERIOD_END;
            cfg_reg.period_accel         <= RST_PERIOD_ACCEL;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_REV_TARGET:    cfg_reg.revolutions_target   <= pwdata[15:0];
                REG_STEPS_PER_REV: cfg_reg.steps_per_revolution <= pwdata[15:0];
                REG_PERIOD_START:  cfg_reg.period_start         <= pwdata[23:0];
                REG_PERIOD_END:    cfg_reg.period_end           <= pwdata[23:0];
                REG_PERIOD_ACCEL:  cfg_reg.period_accel         <= pwdata[23:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_REV_TARGET:    prdata = {16'd0, cfg_reg.revolutions_target};
            REG_STEPS_PER_REV: prdata = {16'd0, cfg_reg.steps_per_revolution};
            REG_PERIOD_START:  prdata = {8'd0, cfg_reg.period_start};
            REG_PERIOD_END:    prdata = {8'd0, cfg_reg.period_end};
            REG_PERIOD_ACCEL:  prdata = {8'd0, cfg_reg.period_accel};
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- sv/srd_core.sv -----
// motor state registers and single-pass next-state logic for one transaction
// depends on srd_pkg
module srd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  srd_pkg::cmd_t        cmd,
    input  logic                 closed_sw,
    input  logic                 open_sw,
    input  srd_pkg::cfg_t        cfg,
    output srd_pkg::res_t        res
);
    import srd_pkg::*;

    logic        running_reg,   running_next;
    logic        closing_reg,   closing_next;
    logic        full_ph_reg,   full_ph_next;
    logic [3:0]  half_pat_reg,  half_pat_next;
    logic [3:0]  full_pat_reg,  full_pat_next;
    logic [15:0] step_cnt_reg,  step_cnt_next;
    logic [15:0] rev_cnt_reg,   rev_cnt_next;
    logic [23:0] period_reg,    period_next;
    logic [3:0]  coil_reg,      coil_next;
    logic        sensor_reg,    sensor_next;

    logic        halt_cond;
    logic [15:0] step_inc;

    assign halt_cond = (rev_cnt_reg >= cfg.revolutions_target)
                    || (closing_reg && closed_sw)
                    || (!closing_reg && open_sw);
    assign step_inc  = step_cnt_reg + 16'd1;

    always_comb
    begin
        running_next  = running_reg;
        closing_next  = closing_reg;
        full_ph_next  = full_ph_reg;
        half_pat_next = half_pat_reg;
        full_pat_next = full_pat_reg;
        step_cnt_next = step_cnt_reg;
        rev_cnt_next  = rev_cnt_reg;
        period_next   = period_reg;
        coil_next     = coil_reg;
        sensor_next   = sensor_reg;
        case (cmd)
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    if (halt_cond)
                    begin
                        coil_next    = 4'd0;
                        running_next = 1'b0;
                        sensor_next  = 1'b0;
                    end
                    else
                    begin
                        if (full_ph_reg)
                        begin
                            coil_next     = full_pat_reg;
                            full_pat_next = rotate_pattern(full_pat_reg, closing_reg);
                            full_ph_next  = 1'b0;
                        end
                        else
                        begin
                            coil_next     = half_pat_reg;
                            half_pat_next = rotate_pattern(half_pat_reg, closing_reg);
                            full_ph_next  = 1'b1;
                        end
                        if (step_inc == cfg.steps_per_revolution)
                        begin
                            step_cnt_next = 16'd0;
                            rev_cnt_next  = rev_cnt_reg + 16'd1;
                        end
                        else
                        begin
                            step_cnt_next = step_inc;
                        end
                        if (period_reg > cfg.period_end)
                        begin
                            if (period_reg > cfg.period_accel)
                            begin
                                period_next = period_reg - cfg.period_accel;
                            end
                            else
                            begin
                                period_next = 24'd0;
                            end
                        end
                    end
                end
            end
            CMD_CLOSE, CMD_OPEN:
            begin
                if (!running_reg && ((cmd == CMD_CLOSE) ? !closed_sw : !open_sw))
                begin
                    sensor_next   = 1'b1;
                    closing_next  = (cmd == CMD_CLOSE);
                    full_ph_next  = (cmd != CMD_CLOSE);
                    half_pat_next = HALF_PATTERN_INIT;
                    full_pat_next = FULL_PATTERN_INIT;
                    step_cnt_next = 16'd0;
                    rev_cnt_next  = 16'd0;
                    period_next   = cfg.period_start;
                    running_next  = 1'b1;
                end
            end
            default:
            begin
                coil_next    = 4'd0;
                running_next = 1'b0;
                sensor_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            closing_reg  <= 1'b0;
            full_ph_reg  <= 1'b0;
            half_pat_reg <= HALF_PATTERN_INIT;
            full_pat_reg <= FULL_PATTERN_INIT;
            step_cnt_reg <= 16'd0;
            rev_cnt_reg  <= 16'd0;
            period_reg   <= 24'd0;
            coil_reg     <= 4'd0;
            sensor_reg   <= 1'b0;
        end
        else if (fire)
        begin
            running_reg  <= running_next;
            closing_reg  <= closing_next;
            full_ph_reg  <= full_ph_next;
            half_pat_reg <= half_pat_next;
            full_pat_reg <= full_pat_next;
            step_cnt_reg <= step_cnt_next;
            rev_cnt_reg  <= rev_cnt_next;
            period_reg   <= period_next;
            coil_reg     <= coil_next;
            sensor_reg   <= sensor_next;
        end
    end

    assign res.coil_drive   = coil_next;
    assign res.is_running   = running_next;
    assign res.sensor_power = sensor_next;
    assign res.step_period  = period_next;

endmodule

// ----- bench/tb_stepper_halfstep_ramp_driver.sv -----
// self-checking testbench for stepper_halfstep_ramp_driver: predicts every result transaction
// and compares it field by field. depends on srd_pkg and the stepper_halfstep_ramp_driver rtl
module tb_stepper_halfstep_ramp_driver;
    timeunit 1ns;
    timeprecision 1ps;

    import srd_pkg::*;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          command;
    logic                closed_switch;
    logic                open_switch;
    logic                out_valid;
    logic                out_ready;
    logic [3:0]          coil_drive;
    logic                is_running;
    logic                sensor_power;
    logic [23:0]         step_period;

    // predicted motor state and configuration
    cfg_t        cfg_now;
    logic        mot_running;
    logic        mot_closing;
    logic        full_next;
    logic [3:0]  half_pat;
    logic [3:0]  full_pat;
    logic [15:0] step_cnt;
    logic [15:0] rev_cnt;
    logic [23:0] period_cur;
    logic [3:0]  coil_reg;
    logic        sensors_on;

    res_t        drive_expect_q[$];
    res_t        want_drive;
    int          err_count;
    int          effective_count;
    int          item_count;
    int          burst_left;
    rx_mode_t    rx_mode;
    int          rx_left;
    int          rx_stall;

    stepper_halfstep_ramp_driver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .closed_switch (closed_switch),
        .open_switch   (open_switch),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .coil_drive    (coil_drive),
        .is_running    (is_running),
        .sensor_power  (sensor_power),
        .step_period   (step_period)
    );

    always #6 clk = ~clk;

    function automatic logic [3:0] rotate_nibble(input logic [3:0] p);
        if (mot_closing)
        begin
            return {p[2:0], p[3]};
        end
        return {p[0], p[3:1]};
    endfunction

    function automatic void halt_motor();
        coil_reg = 4'd0;
        mot_running = 1'b0;
        sensors_on = 1'b0;
    endfunction

    function automatic void start_move(input logic closing);
        sensors_on = 1'b1;
        mot_closing = closing;
        full_next = !closing;
        half_pat = HALF_PATTERN_INIT;
        full_pat = FULL_PATTERN_INIT;
        step_cnt = 16'd0;
        rev_cnt = 16'd0;
        period_cur = cfg_now.period_start;
        mot_running = 1'b1;
    endfunction

    // updates the predicted state for one command and returns the drive it leads to
    function automatic res_t next_drive_state(input cmd_t cmd, input logic cs, input logic os,
                                              output bit effective);
        res_t r;
        effective = 1'b1;
        case (cmd)
            CMD_TICK:
            begin
                if (!mot_running)
                begin
                    effective = 1'b0;
                end
                else if (rev_cnt >= cfg_now.revolutions_target ||
                         (mot_closing && cs) || (!mot_closing && os))
                begin
                    halt_motor();
                end
                else
                begin
                    if (full_next)
                    begin
                        coil_reg = full_pat;
                        full_pat = rotate_nibble(full_pat);
                        full_next = 1'b0;
                    end
                    else
                    begin
                        coil_reg = half_pat;
                        half_pat = rotate_nibble(half_pat);
                        full_next = 1'b1;
                    end
                    step_cnt = step_cnt + 16'd1;
                    if (step_cnt == cfg_now.steps_per_revolution)
                    begin
                        rev_cnt = rev_cnt + 16'd1;
                        step_cnt = 16'd0;
                    end
                    if (period_cur > cfg_now.period_end)
                    begin
                        if (period_cur > cfg_now.period_accel)
                        begin
                            period_cur = period_cur - cfg_now.period_accel;
                        end
                        else
                        begin
                            period_cur = 24'd0;
                        end
                    end
                end
            end
            CMD_CLOSE:
            begin
                if (!mot_running && !cs)
                begin
                    start_move(1'b1);
                end
                else
                begin
                    effective = 1'b0;
                end
            end
            CMD_OPEN:
            begin
                if (!mot_running && !os)
                begin
                    start_move(1'b0);
                end
                else
                begin
                    effective = 1'b0;
                end
            end
            default:
            begin
                halt_motor();
            end
        endcase
        r.coil_drive = coil_reg;
        r.is_running = mot_running;
        r.sensor_power = sensors_on;
        r.step_period = period_cur;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        err_count++;
        if (err_count <= 40)
        begin
            $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_expect_q.size() == 0)
            begin
                report_mismatch("unexpected result transaction", step_period, 24'd0);
            end
            else
            begin
                want_drive = drive_expect_q.pop_front();
                if (coil_drive !== want_drive.coil_drive)
                    report_mismatch("coil_drive", 24'(coil_drive),
                                    24'(want_drive.coil_drive));
                if (is_running !== want_drive.is_running)
                    report_mismatch("is_running", 24'(is_running),
                                    24'(want_drive.is_running));
                if (sensor_power !== want_drive.sensor_power)
                    report_mismatch("sensor_power", 24'(sensor_power),
                                    24'(want_drive.sensor_power));
                if (step_period !== want_drive.step_period)
                    report_mismatch("step_period", step_period, want_drive.step_period);
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   out_ready = 1'b1;
            RX_COIN:   out_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
            default:
            begin
                if (rx_stall > 0)
                begin
                    out_ready = 1'b0;
                    rx_stall--;
                end
                else
                begin
                    out_ready = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_stall = $urandom_range(1, 6);
                end
            end
        endcase
    end

    // starts and ends at a falling edge
    task automatic send_item(input cmd_t cmd, input logic cs, input logic os);
        int gap;
        bit effective;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(30, 80);
            end
            else
            begin
                gap = $urandom_range(0, 4);
                burst_left = $urandom_range(1, 16);
            end
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        command = cmd;
        closed_switch = cs;
        open_switch = os;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        drive_expect_q.push_back(next_drive_state(cmd, cs, os, effective));
        item_count++;
        if (effective)
            effective_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid = 1'b0;
        while (drive_expect_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (drive_expect_q.size() != 0)
        begin
            report_mismatch("results never delivered", 24'd0, 24'(drive_expect_q.size()));
            drive_expect_q.delete();
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (reg_idx)
            REG_REV_TARGET:    cfg_now.revolutions_target = value[15:0];
            REG_STEPS_PER_REV: cfg_now.steps_per_revolution = value[15:0];
            REG_PERIOD_START:  cfg_now.period_start = value[23:0];
            REG_PERIOD_END:    cfg_now.period_end = value[23:0];
            default:           cfg_now.period_accel = value[23:0];
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] target, input logic [15:0] steps,
                                  input logic [23:0] p_start, input logic [23:0] p_end,
                                  input logic [23:0] p_accel);
        apb_write(REG_REV_TARGET, {16'd0, target});
        apb_write(REG_STEPS_PER_REV, {16'd0, steps});
        apb_write(REG_PERIOD_START, {8'd0, p_start});
        apb_write(REG_PERIOD_END, {8'd0, p_end});
        apb_write(REG_PERIOD_ACCEL, {8'd0, p_accel});
    endtask

    // defaults after reset: idle commands, blocked starts, zero revolution target
    task automatic test_idle_commands();
        send_item(CMD_TICK, 1'b1, 1'b1);
        send_item(CMD_STOP, 1'b0, 1'b0);
        send_item(CMD_CLOSE, 1'b1, 1'b0);
        send_item(CMD_OPEN, 1'b0, 1'b1);
        send_item(CMD_OPEN, 1'b0, 1'b0);
        send_item(CMD_TICK, 1'b0, 1'b0);
    endtask

    // revolution target, limit switches, stop while running, period saturation
    task automatic test_directed_motion();
        wait_drained();
        write_all_regs(16'd2, 16'd3, 24'd20, 24'd0, 24'd7);
        send_item(CMD_CLOSE, 1'b0, 1'b1);
        send_item(CMD_TICK, 1'b0, 1'b1);
        send_item(CMD_TICK, 1'b0, 1'b0);
        send_item(CMD_OPEN, 1'b0, 1'b0);
        repeat (5) send_item(CMD_TICK, 1'b0, 1'b0);
        send_item(CMD_OPEN, 1'b0, 1'b0);
        send_item(CMD_TICK, 1'b1, 1'b0);
        send_item(CMD_TICK, 1'b0, 1'b1);
        send_item(CMD_CLOSE, 1'b0, 1'b0);
        send_item(CMD_TICK, 1'b0, 1'b1);
        send_item(CMD_STOP, 1'b1, 1'b1);
    endtask

    // register extremes, change of period_end during a movement
    task automatic test_config_extremes();
        wait_drained();
        write_all_regs(16'hFFFF, 16'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_item(CMD_OPEN, 1'b0, 1'b0);
        send_item(CMD_TICK, 1'b0, 1'b0);
        send_item(CMD_TICK, 1'b1, 1'b0);
        wait_drained();
        apb_write(REG_PERIOD_END, 32'd0);
        send_item(CMD_TICK, 1'b0, 1'b0);
        send_item(CMD_TICK, 1'b0, 1'b0);
        send_item(CMD_STOP, 1'b0, 1'b0);
    endtask

    // lowering steps_per_revolution below the count: no revolution is counted early
    task automatic test_step_count_wrap();
        wait_drained();
        write_all_regs(16'd2, 16'd8, 24'd1000, 24'hFFFFFF, 24'd5);
        send_item(CMD_CLOSE, 1'b0, 1'b0);
        repeat (5) send_item(CMD_TICK, 1'b0, 1'($urandom_range(0, 1)));
        wait_drained();
        apb_write(REG_STEPS_PER_REV, 32'd3);
        repeat (40) send_item(CMD_TICK, 1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_moves();
        int start_count;
        int phase_left;
        int pick;
        logic travel_sw;
        logic other_sw;
        logic [15:0] target;
        logic [15:0] steps;
        logic [23:0] p_start;
        logic [23:0] p_end;
        logic [23:0] p_accel;
        start_count = item_count;
        while (item_count - start_count < 780)
        begin
            wait_drained();
            case ($urandom_range(0, 4))
                0:       target = 16'd0;
                1:       target = 16'd1;
                2:       target = 16'($urandom_range(2, 6));
                3:       target = 16'hFFFF;
                default: target = 16'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       steps = 16'd1;
                1:       steps = 16'($urandom_range(2, 12));
                2:       steps = 16'd400;
                3:       steps = 16'hFFFF;
                default: steps = 16'($urandom_range(1, 16'hFFFF));
            endcase
            case ($urandom_range(0, 3))
                0:       p_start = 24'd0;
                1:       p_start = 24'hFFFFFF;
                2:       p_start = 24'($urandom());
                default: p_start = 24'($urandom_range(0, 300));
            endcase
            case ($urandom_range(0, 3))
                0:       p_end = 24'd0;
                1:       p_end = 24'hFFFFFF;
                2:       p_end = 24'($urandom());
                default: p_end = 24'($urandom_range(0, 200));
            endcase
            case ($urandom_range(0, 3))
                0:       p_accel = 24'd0;
                1:       p_accel = 24'hFFFFFF;
                2:       p_accel = 24'($urandom());
                default: p_accel = 24'($urandom_range(0, 50));
            endcase
            write_all_regs(target, steps, p_start, p_end, p_accel);
            phase_left = $urandom_range(40, 100);
            while (phase_left > 0 && item_count - start_count < 780)
            begin
                phase_left--;
                pick = $urandom_range(0, 99);
                other_sw = 1'($urandom_range(0, 1));
                if (!mot_running)
                begin
                    travel_sw = ($urandom_range(0, 7) == 0);
                    if (pick < 35)
                        send_item(CMD_CLOSE, travel_sw, other_sw);
                    else if (pick < 70)
                        send_item(CMD_OPEN, other_sw, travel_sw);
                    else if (pick < 85)
                        send_item(CMD_TICK, 1'($urandom_range(0, 1)), other_sw);
                    else
                        send_item(CMD_STOP, 1'($urandom_range(0, 1)), other_sw);
                end
                else
                begin
                    travel_sw = ($urandom_range(0, 39) == 0);
                    if (pick < 86)
                    begin
                        if (mot_closing)
                            send_item(CMD_TICK, travel_sw, other_sw);
                        else
                            send_item(CMD_TICK, other_sw, travel_sw);
                    end
                    else if (pick < 92)
                        send_item(pick[0] ? CMD_CLOSE : CMD_OPEN, 1'($urandom_range(0, 1)),
                                  other_sw);
                    else
                        send_item(CMD_STOP, 1'($urandom_range(0, 1)), other_sw);
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_TICK;
        closed_switch = 1'b0;
        open_switch = 1'b0;
        out_ready = 1'b0;
        err_count = 0;
        effective_count = 0;
        item_count = 0;
        burst_left = 0;
        cfg_now.revolutions_target = RST_REV_TARGET;
        cfg_now.steps_per_revolution = RST_STEPS_PER_REV;
        cfg_now.period_start = RST_PERIOD_START;
        cfg_now.period_end = RST_PERIOD_END;
        cfg_now.period_accel = RST_PERIOD_ACCEL;
        mot_running = 1'b0;
        mot_closing = 1'b0;
        full_next = 1'b0;
        half_pat = HALF_PATTERN_INIT;
        full_pat = FULL_PATTERN_INIT;
        step_cnt = 16'd0;
        rev_cnt = 16'd0;
        period_cur = 24'd0;
        coil_reg = 4'd0;
        sensors_on = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_idle_commands();
        test_directed_motion();
        test_config_extremes();
        test_step_count_wrap();
        test_random_moves();
        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0)
        begin
            $display("stepper_halfstep_ramp_driver: match");
        end
        else
        begin
            $display("stepper_halfstep_ramp_driver: mismatch");
        end
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("stepper_halfstep_ramp_driver: mismatch");
        $finish;
    end

endmodule
